// ===== design/chim_pkg.sv =====
// shared types, constants and codes of the coordinate hash index map
`timescale 1ns / 1ps
`default_nettype none

package chim_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int GEN_BITS    = 16;
    localparam int KEY_W       = 64;
    localparam int INDEX_W     = 10;
    localparam int COUNT_W     = 11;
    localparam int COORD_W     = 26;
    localparam int Y_W         = 12;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 3;

    // an insert that would bring the load above 70 percent is refused
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'((TABLE_SLOTS * 7 + 9) / 10 - 1);

    localparam logic [SLOT_W-1:0]   SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [GEN_BITS-1:0] GEN_LAST  = '1;
    localparam logic [GEN_BITS-1:0] GEN_FIRST = GEN_BITS'(1);

    // splitmix64 finalizer multipliers
    localparam logic [KEY_W-1:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [KEY_W-1:0] MIX_MUL_B = 64'h94d049bb133111eb;

    // commands
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_FOUND    = 3'd0;
    localparam logic [STATUS_W-1:0] STS_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] STS_ABSENT   = 3'd2;
    localparam logic [STATUS_W-1:0] STS_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] STS_CLEARED  = 3'd4;

    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [GEN_BITS-1:0] gen_t;
    typedef logic [INDEX_W-1:0]  index_t;
    typedef logic [COUNT_W-1:0]  count_t;

    typedef struct packed {
        key_t   key;
        index_t idx;
        gen_t   tag;
    } entry_t;

    typedef struct packed {
        logic   en;
        slot_t  addr;
        entry_t data;
    } store_wr_t;

    typedef struct packed {
        logic  start;
        key_t  key;
    } hash_req_t;

    typedef struct packed {
        logic  done;
        slot_t slot;
    } hash_rsp_t;

endpackage

`default_nettype wire

// ===== design/chim_if.sv =====
// request and response channel interfaces of the coordinate hash index map
`timescale 1ns / 1ps
`default_nettype none

interface chim_req_if
    import chim_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic signed [COORD_W-1:0] coord_x;
    logic [Y_W-1:0]            coord_y;
    logic signed [COORD_W-1:0] coord_z;

    modport source (output valid, cmd, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, cmd, coord_x, coord_y, coord_z, output ready);
endinterface

interface chim_rsp_if
    import chim_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  record_index;

    modport source (output valid, status, record_index, input ready);
    modport sink   (input valid, status, record_index, output ready);
endinterface

`default_nettype wire

// ===== design/coord_hash_index_map.sv =====
// top level of the coordinate hash index map: control sequencer and result register
`timescale 1ns / 1ps
`default_nettype none

// Maps a grid cell (x, y, z) to a dense record index in a 1024-slot open-addressed
// table held in one synchronous memory. One item is worked at a time. After reset
// the block runs a pass that zeroes every generation tag and takes no item until
// it ends. A lookup or find-or-insert first runs the splitmix64 hash, which makes
// six passes over a single 32x32 multiplier, then probes slots one memory read per
// cycle until it meets a free slot or the key. A clear or an unused command goes
// straight to its result; once every 65535 clears the generation counter wraps and
// the clear runs the tag pass before its result. Inserts are refused with a full
// status once 716 records are held. The result waits in an output register, and
// the next item is taken while it waits.
module coord_hash_index_map
    import chim_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    chim_req_if.sink   req,
    chim_rsp_if.source rsp
);

    typedef enum logic [4:0] {
        S_SWEEP = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_PROBE = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    gen_t   gen_reg, gen_next;
    count_t count_reg, count_next;
    slot_t  sweep_addr_reg, sweep_addr_next;
    logic   sweep_resp_reg, sweep_resp_next;
    logic   is_insert_reg, is_insert_next;
    logic   out_valid_reg, out_valid_next;

    key_t                key_reg, key_next;
    slot_t               slot_reg, slot_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    index_t              res_index_reg, res_index_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    index_t              out_index_reg, out_index_next;

    logic      accept;
    key_t      in_key;
    hash_req_t hash_req;
    hash_rsp_t hash_rsp;
    store_wr_t wr;
    slot_t     rd_addr;
    entry_t    rd_data;

    chim_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hash_req),
        .rsp   (hash_rsp)
    );

    chim_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign in_key    = {req.coord_x, req.coord_z, req.coord_y};

    always_comb
    begin
        state_next      = state_reg;
        gen_next        = gen_reg;
        count_next      = count_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_resp_next = sweep_resp_reg;
        is_insert_next  = is_insert_reg;
        out_valid_next  = out_valid_reg;
        key_next        = key_reg;
        slot_next       = slot_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        hash_req.start  = 1'b0;
        hash_req.key    = in_key;
        wr              = '0;
        rd_addr         = slot_reg + SLOT_W'(1);

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_SWEEP:
            begin
                wr.en           = 1'b1;
                wr.addr         = sweep_addr_reg;
                wr.data         = '0;
                sweep_addr_next = sweep_addr_reg + SLOT_W'(1);
                if (sweep_addr_reg == SLOT_LAST)
                begin
                    sweep_resp_next = 1'b0;
                    state_next      = sweep_resp_reg ? S_RESP : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next       = in_key;
                    is_insert_next = (req.cmd == CMD_INSERT);
                    res_index_next = '0;
                    case (req.cmd)
                        CMD_CLEAR:
                        begin
                            count_next      = '0;
                            res_status_next = STS_CLEARED;
                            if (gen_reg == GEN_LAST)
                            begin
                                // generation wraps: old tags could alias, wipe them
                                gen_next        = GEN_FIRST;
                                sweep_resp_next = 1'b1;
                                sweep_addr_next = '0;
                                state_next      = S_SWEEP;
                            end
                            else
                            begin
                                gen_next   = gen_reg + GEN_BITS'(1);
                                state_next = S_RESP;
                            end
                        end
                        CMD_LOOKUP, CMD_INSERT:
                        begin
                            hash_req.start = 1'b1;
                            state_next     = S_HASH;
                        end
                        default:
                        begin
                            res_status_next = STS_ABSENT;
                            state_next      = S_RESP;
                        end
                    endcase
                end
            end
            S_HASH:
            begin
                rd_addr = hash_rsp.slot;
                if (hash_rsp.done)
                begin
                    slot_next  = hash_rsp.slot;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                // the read of the following slot is already issued each cycle
                if (rd_data.tag != gen_reg)
                begin
                    state_next     = S_RESP;
                    res_index_next = '0;
                    if (!is_insert_reg)
                    begin
                        res_status_next = STS_ABSENT;
                    end
                    else if (count_reg >= FULL_COUNT)
                    begin
                        res_status_next = STS_FULL;
                    end
                    else
                    begin
                        wr.en           = 1'b1;
                        wr.addr         = slot_reg;
                        wr.data.key     = key_reg;
                        wr.data.idx     = count_reg[INDEX_W-1:0];
                        wr.data.tag     = gen_reg;
                        res_status_next = STS_INSERTED;
                        res_index_next  = count_reg[INDEX_W-1:0];
                        count_next      = count_reg + COUNT_W'(1);
                    end
                end
                else if (rd_data.key == key_reg)
                begin
                    res_status_next = STS_FOUND;
                    res_index_next  = rd_data.idx;
                    state_next      = S_RESP;
                end
                else
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = res_index_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            gen_reg        <= GEN_FIRST;
            count_reg      <= '0;
            sweep_addr_reg <= '0;
            sweep_resp_reg <= 1'b0;
            is_insert_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            gen_reg        <= gen_next;
            count_reg      <= count_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_resp_reg <= sweep_resp_next;
            is_insert_reg  <= is_insert_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.record_index = out_index_reg;

endmodule

`default_nettype wire

// ===== design/chim_hash.sv =====
// splitmix64 finalizer on one shared 32x32 multiplier, giving the home slot
`timescale 1ns / 1ps
`default_nettype none

module chim_hash
    import chim_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire hash_req_t req,
    output hash_rsp_t      rsp
);

    localparam logic [1:0] STEP_LO   = 2'd0;
    localparam logic [1:0] STEP_HI_A = 2'd1;
    localparam logic [1:0] STEP_HI_B = 2'd2;

    logic        busy_reg;
    logic        phase_reg;
    logic [1:0]  step_reg;
    key_t        opnd_reg;
    key_t        acc_reg;
    logic        done_reg;
    slot_t       slot_reg;

    key_t        mul_const;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    key_t        acc_next;
    key_t        mix_a;
    key_t        mix_b;

    assign mul_const = phase_reg ? MIX_MUL_B : MIX_MUL_A;

    // low 64 bits of a 64x64 product as three 32x32 partial products
    always_comb
    begin
        mul_a    = opnd_reg[31:0];
        mul_b    = mul_const[31:0];
        acc_next = acc_reg;
        case (step_reg)
            STEP_LO:
            begin
                mul_a = opnd_reg[31:0];
                mul_b = mul_const[31:0];
            end
            STEP_HI_A:
            begin
                mul_a = opnd_reg[63:32];
                mul_b = mul_const[31:0];
            end
            STEP_HI_B:
            begin
                mul_a = opnd_reg[31:0];
                mul_b = mul_const[63:32];
            end
            default:
            begin
                mul_a = opnd_reg[31:0];
                mul_b = mul_const[31:0];
            end
        endcase
        prod = {32'b0, mul_a} * {32'b0, mul_b};
        if (step_reg == STEP_LO)
        begin
            acc_next = prod;
        end
        else
        begin
            acc_next = acc_reg + {prod[31:0], 32'b0};
        end
    end

    assign mix_a = acc_next ^ (acc_next >> 27);
    assign mix_b = acc_next ^ (acc_next >> 31);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            step_reg  <= STEP_LO;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
                step_reg  <= STEP_LO;
            end
            else if (busy_reg)
            begin
                if (step_reg == STEP_HI_B)
                begin
                    step_reg <= STEP_LO;
                    if (phase_reg)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        phase_reg <= 1'b1;
                    end
                end
                else
                begin
                    step_reg <= step_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            opnd_reg <= req.key ^ (req.key >> 30);
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            if (step_reg == STEP_HI_B)
            begin
                if (phase_reg)
                begin
                    slot_reg <= mix_b[SLOT_W-1:0];
                end
                else
                begin
                    opnd_reg <= mix_a;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.slot = slot_reg;

endmodule

`default_nettype wire

// ===== design/chim_store.sv =====
// slot memory: key, record index and generation tag, one write and one read port
`timescale 1ns / 1ps
`default_nettype none

module chim_store
    import chim_pkg::*;
(
    input  wire logic      clk,
    input  wire store_wr_t wr,
    input  wire slot_t     rd_addr,
    output entry_t         rd_data
);

    entry_t mem [TABLE_SLOTS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/chim_checker.sv =====
// port-level checks of the coordinate hash index map and their bind
`timescale 1ns / 1ps
`default_nettype none

module chim_checker
    import chim_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                req_valid,
    input wire logic                req_ready,
    input wire logic                rsp_valid,
    input wire logic                rsp_ready,
    input wire logic [STATUS_W-1:0] status,
    input wire logic [INDEX_W-1:0]  record_index
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(record_index))
        else $error("result changed while stalled");

    // one item at a time: intake closes right after an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item taken while another is in work");

    // only found and inserted carry an index
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STS_ABSENT || status == STS_FULL || status == STS_CLEARED)
        |-> record_index == '0)
        else $error("index on a result that carries none");

    // no status code beyond cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> status <= STS_CLEARED)
        else $error("unknown status code");

endmodule

bind coord_hash_index_map chim_checker u_chim_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.status),
    .record_index (rsp.record_index)
);

`default_nettype wire
